>>> rtl/rle_pkg.sv
`timescale 1ns / 1ps

package rle_pkg;

   localparam int BitsPerPixel = 24;
   localparam int CountWidth   = $clog2(BitsPerPixel);

   localparam logic [1:0] CsrBrightness = 2'd0;
   localparam logic [1:0] CsrLongTicks  = 2'd1;
   localparam logic [1:0] CsrShortTicks = 2'd2;

   localparam logic [7:0] BrightnessReset = 8'd255;
   localparam logic [7:0] LongTicksReset  = 8'd8;
   localparam logic [7:0] ShortTicksReset = 8'd4;

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] long_ticks;
      logic [7:0] short_ticks;
   } cfg_type;

   typedef struct packed {
      logic [BitsPerPixel-1:0] word;
      logic                    last;
   } pixel_type;

   // exact x / 255 for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

>>> rtl/rgb_led_bit_encoder.sv
// data path: an accepted pixel is registered as scaled products, queued in a two-entry
//    queue, then sent as 24 symbols per pixel, one symbol per cycle while the receiver
//    does not stall, by the serializer in the back end, whose outputs are registered
// reset: synchronous, active high; clears the queue and pipeline, brightness 255,
//    long ticks 8, short ticks 4
`timescale 1ns / 1ps

module rgb_led_bit_encoder import rle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       req_last_pixel,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_high_ticks,
   output logic [7:0] rsp_low_ticks,
   output logic       rsp_pixel_done,
   output logic       rsp_frame_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      push, queue_full, pop, head_valid;
   pixel_type push_data, head_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrBrightness: cfg_in.brightness  = csr_data;
            CsrLongTicks:  cfg_in.long_ticks  = csr_data;
            CsrShortTicks: cfg_in.short_ticks = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness  <= BrightnessReset;
         cfg_ff.long_ticks  <= LongTicksReset;
         cfg_ff.short_ticks <= ShortTicksReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .cfg            (cfg_ff),
      .push           (push),
      .push_data      (push_data),
      .queue_full     (queue_full)
   );

   rle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_high_ticks (rsp_high_ticks),
      .rsp_low_ticks  (rsp_low_ticks),
      .rsp_pixel_done (rsp_pixel_done),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

>>> rtl/rle_front.sv
`timescale 1ns / 1ps

module rle_front import rle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       req_last_pixel,
   input  cfg_type    cfg,
   output logic       push,
   output pixel_type  push_data,
   input  logic       queue_full
);

   logic        prod_valid_ff, prod_valid_in;
   logic [15:0] red_ff, green_ff, blue_ff;
   logic        last_ff;
   logic        take;

   assign req_stall = prod_valid_ff && queue_full;
   assign take      = req_valid && !req_stall;
   assign push      = prod_valid_ff && !queue_full;

   assign push_data.word = {div255(green_ff), div255(red_ff), div255(blue_ff)};
   assign push_data.last = last_ff;

   always_comb begin
      prod_valid_in = prod_valid_ff;
      if (take) begin
         prod_valid_in = 1'b1;
      end else if (push) begin
         prod_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         red_ff   <= req_red * cfg.brightness;
         green_ff <= req_green * cfg.brightness;
         blue_ff  <= req_blue * cfg.brightness;
         last_ff  <= req_last_pixel;
      end
   end

endmodule

>>> rtl/rle_queue.sv
`timescale 1ns / 1ps

module rle_queue import rle_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  pixel_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output pixel_type head_data
);

   pixel_type   entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/rle_back.sv
`timescale 1ns / 1ps

module rle_back import rle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       head_valid,
   input  pixel_type  head_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_high_ticks,
   output logic [7:0] rsp_low_ticks,
   output logic       rsp_pixel_done,
   output logic       rsp_frame_end
);

   localparam logic [CountWidth-1:0] LastCount = CountWidth'(BitsPerPixel - 1);

   logic [CountWidth-1:0]   cnt_ff, cnt_in;
   logic [BitsPerPixel-2:0] shift_ff, shift_in;
   logic                    last_ff, last_in;
   logic                    valid_ff, valid_in;
   logic [7:0]              high_ff, high_in;
   logic [7:0]              low_ff, low_in;
   logic                    done_ff, done_in;
   logic                    fend_ff, fend_in;
   logic                    advance, start, avail, emit, cur_bit, final_sym;

   assign advance   = !valid_ff || !rsp_stall;
   assign start     = (cnt_ff == '0);
   assign avail     = !start || head_valid;
   assign emit      = advance && avail;
   assign pop       = emit && start;
   assign final_sym = (cnt_ff == LastCount);
   assign cur_bit   = start ? head_data.word[BitsPerPixel-1] : shift_ff[BitsPerPixel-2];

   always_comb begin
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      last_in  = last_ff;
      valid_in = advance ? 1'b0 : valid_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      done_in  = done_ff;
      fend_in  = fend_ff;
      if (emit) begin
         cnt_in   = final_sym ? '0 : cnt_ff + 1'b1;
         valid_in = 1'b1;
         high_in  = cur_bit ? cfg.long_ticks : cfg.short_ticks;
         low_in   = cur_bit ? cfg.short_ticks : cfg.long_ticks;
         done_in  = final_sym;
         fend_in  = final_sym && last_ff;
         if (start) begin
            shift_in = head_data.word[BitsPerPixel-2:0];
            last_in  = head_data.last;
         end else begin
            shift_in = {shift_ff[BitsPerPixel-3:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      last_ff  <= last_in;
      high_ff  <= high_in;
      low_ff   <= low_in;
      done_ff  <= done_in;
      fend_ff  <= fend_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_high_ticks = high_ff;
   assign rsp_low_ticks  = low_ff;
   assign rsp_pixel_done = done_ff;
   assign rsp_frame_end  = fend_ff;

endmodule

>>> tb/rgb_led_bit_encoder_test.sv
`timescale 1ns / 1ps

module rgb_led_bit_encoder_test import rle_pkg::*;;

   localparam logic [1:0] CsrUnused = 2'd3;
   localparam int QuietLimit = 3000;
   localparam int HoldCycles = 300;
   localparam int MaxReports = 20;

   typedef struct packed {
      logic [7:0] high_ticks;
      logic [7:0] low_ticks;
      logic       pixel_done;
      logic       frame_end;
   } symbol_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_red = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue = 8'd0;
   logic       req_last_pixel = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_high_ticks;
   logic [7:0] rsp_low_ticks;
   logic       rsp_pixel_done;
   logic       rsp_frame_end;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_data = 8'd0;

   symbol_type expected_symbols[$];
   cfg_type    strip_cfg;

   int send_idle_pct = 23;
   int stall_pct = 59;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int pixels_sent = 0;
   int symbols_checked = 0;
   int csr_writes = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   rgb_led_bit_encoder uut (.*);

   always #10 clock = ~clock;

   // brightness scaling, truncating
   function automatic logic [7:0] scale_by_brightness(input logic [7:0] level);
      int product;
      product = (int'(level) * int'(strip_cfg.brightness)) / 255;
      return product[7:0];
   endfunction

   function automatic void predict_pixel(input logic [7:0] red, input logic [7:0] green,
                                         input logic [7:0] blue, input logic last);
      logic [23:0] word;
      symbol_type  sym;
      word = {scale_by_brightness(green), scale_by_brightness(red), scale_by_brightness(blue)};
      for (int k = BitsPerPixel - 1; k >= 0; k--) begin
         sym.high_ticks = word[k] ? strip_cfg.long_ticks : strip_cfg.short_ticks;
         sym.low_ticks  = word[k] ? strip_cfg.short_ticks : strip_cfg.long_ticks;
         sym.pixel_done = (k == 0);
         sym.frame_end  = (k == 0) && last;
         expected_symbols.push_back(sym);
      end
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         if (error_count <= MaxReports)
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin : symbol_checker
      symbol_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            error_count++;
            if (error_count <= MaxReports)
               $display("%0t: unexpected symbol, expected none, actual high %0d low %0d",
                        $time, rsp_high_ticks, rsp_low_ticks);
         end else begin
            want = expected_symbols.pop_front();
            compare_field("high_ticks", want.high_ticks, rsp_high_ticks);
            compare_field("low_ticks", want.low_ticks, rsp_low_ticks);
            compare_field("pixel_done", want.pixel_done, rsp_pixel_done);
            compare_field("frame_end", want.frame_end, rsp_frame_end);
            symbols_checked++;
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HoldCycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("rgb_led_bit_encoder_test: errors");
         $finish;
      end
   end

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic last);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_red        <= red;
      req_green      <= green;
      req_blue       <= blue;
      req_last_pixel <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(red, green, blue, last);
      pixels_sent++;
   endtask

   task automatic send_random_pixel();
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 1'($urandom_range(1)));
   endtask

   // lowers valid and waits for every symbol to come out
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_register(input logic [1:0] index, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CsrBrightness: strip_cfg.brightness = data;
         CsrLongTicks:  strip_cfg.long_ticks = data;
         CsrShortTicks: strip_cfg.short_ticks = data;
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_register_value();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd1;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic test_default_config();
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
      send_pixel(8'h01, 8'h80, 8'hF0, 1'b1);
      settle();
   endtask

   task automatic test_brightness();
      // zero brightness gives all zero bits
      set_register(CsrBrightness, 8'd0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      settle();
      set_register(CsrBrightness, 8'd1);
      send_pixel(8'hFF, 8'hFE, 8'h80, 1'b0);
      settle();
      set_register(CsrBrightness, 8'd128);
      send_pixel(8'hFF, 8'h80, 8'h01, 1'b1);
      settle();
      set_register(CsrBrightness, 8'd254);
      send_pixel(8'hFF, 8'h64, 8'h03, 1'b0);
      settle();
      set_register(CsrBrightness, 8'd255);
   endtask

   task automatic test_tick_registers();
      logic [7:0] long_set[6]  = '{8'd0, 8'd255, 8'd1, 8'd7, 8'd3, 8'd255};
      logic [7:0] short_set[6] = '{8'd0, 8'd1, 8'd255, 8'd7, 8'd9, 8'd255};
      for (int i = 0; i < 6; i++) begin
         set_register(CsrLongTicks, long_set[i]);
         set_register(CsrShortTicks, short_set[i]);
         send_pixel(8'hA5, 8'h5A, 8'hC3, i[0]);
         settle();
      end
      set_register(CsrLongTicks, LongTicksReset);
      set_register(CsrShortTicks, ShortTicksReset);
   endtask

   // writes to the spare index must leave the registers alone
   task automatic test_unknown_index();
      set_register(CsrUnused, 8'h00);
      send_pixel(8'h3C, 8'hC3, 8'h81, 1'b0);
      settle();
      set_register(CsrUnused, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h7E, 1'b1);
      settle();
   endtask

   task automatic test_random_traffic(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            settle();
            set_register(CsrBrightness, pick_register_value());
            set_register(CsrLongTicks, pick_register_value());
            set_register(CsrShortTicks, pick_register_value());
         end
         send_random_pixel();
      end
      settle();
   endtask

   // receiver holds off while pixels keep coming, so the input backs up
   task automatic test_backpressure(input int count);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      for (int i = 0; i < count; i++) send_random_pixel();
      settle();
   endtask

   initial begin
      strip_cfg.brightness  = BrightnessReset;
      strip_cfg.long_ticks  = LongTicksReset;
      strip_cfg.short_ticks = ShortTicksReset;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_config();
      test_brightness();
      test_tick_registers();
      test_unknown_index();
      test_random_traffic(110, 23, 59);
      test_random_traffic(110, 59, 23);
      test_random_traffic(110, 0, 0);
      test_backpressure(30);

      repeat (30) @(posedge clock);
      if (expected_symbols.size() != 0) begin
         error_count++;
         $display("%0t: %0d symbols never arrived", $time, expected_symbols.size());
      end
      $display("%0d pixels, %0d symbols checked, %0d register writes, %0d mismatches",
               pixels_sent, symbols_checked, csr_writes, error_count);
      $display("covered brightness and tick extremes, spare index, idle mixes, long hold-off");
      if (error_count == 0)
         $display("rgb_led_bit_encoder_test: clean");
      else
         $display("rgb_led_bit_encoder_test: errors");
      $finish;
   end

endmodule
